### design/ffvf_pkg.sv
// ----------------------------------------------------------------------------
// ffvf_pkg
// Shared constants and types for the frame-to-field vertical filter: sizes of
// the line stores and counters, register widths, reset values and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package ffvf_pkg;

    // Largest supported row length and field height.
    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_FIELD_ROWS = 1024;

    // Pixel and filter arithmetic widths.
    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 2;
    localparam int ROUND_BIAS = 2;

    // Counter widths follow from the limits above.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(2 * MAX_FIELD_ROWS);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int RWS_W = $clog2(MAX_FIELD_ROWS + 1);

    // Configuration register widths and reset values.
    localparam int LINE_WIDTH_W   = 12;
    localparam int FIELD_ROWS_W   = 11;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_IDX_W      = 1;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd704;
    localparam logic [FIELD_ROWS_W-1:0] FIELD_ROWS_RST = 11'd288;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_FIELD_ROWS = 1'b1
    } t_cfg_idx;

endpackage

### design/ffvf_in_if.sv
// ----------------------------------------------------------------------------
// ffvf_in_if
// Source pixel channel: one plane pixel per transaction with a frame start
// flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffvf_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffvf_pkg::PIX_W-1:0] pixel_in;
    logic                       frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

### design/ffvf_out_if.sv
// ----------------------------------------------------------------------------
// ffvf_out_if
// Field pixel channel: one filtered pixel per transaction with a field end
// flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffvf_out_if;
    logic                       valid;
    logic                       ready;
    logic [ffvf_pkg::PIX_W-1:0] pixel_out;
    logic                       field_end;

    modport source (output valid, output pixel_out, output field_end, input ready);
    modport sink   (input valid, input pixel_out, input field_end, output ready);
endinterface

### design/frame_to_field_vertical_filter_top.sv
// A field pixel passes stage one and then the output register before it appears.
// Throughput: one source pixel per cycle while stage one can advance; each line
// store reads and writes the accepted column in the same cycle, in read-first order.
// Reset (synchronous, active low) clears the counters, the pipeline valids and
// restores line_width = 704 and field_rows = 288; line store contents are kept.
// ----------------------------------------------------------------------------
// frame_to_field_vertical_filter_top
// Vertical 1-2-1 filter with decimation by two. Even and odd source rows are
// held in two line stores; each even row from row 2 on, and the last odd row,
// completes one output row of the field.
// ----------------------------------------------------------------------------
module frame_to_field_vertical_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  ffvf_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [ffvf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ffvf_in_if.sink                             i_src,
    ffvf_out_if.source                          o_dst
);

    // Configuration registers.
    logic [ffvf_pkg::LINE_WIDTH_W-1:0] r_line_width;
    logic [ffvf_pkg::FIELD_ROWS_W-1:0] r_field_rows;

    // Position counters.
    logic [ffvf_pkg::COL_W-1:0] r_col, n_col;
    logic [ffvf_pkg::ROW_W-1:0] r_row, n_row;

    // Line stores and their registered read data.
    logic [ffvf_pkg::PIX_W-1:0] r_even_line [ffvf_pkg::MAX_WIDTH];
    logic [ffvf_pkg::PIX_W-1:0] r_odd_line  [ffvf_pkg::MAX_WIDTH];
    logic [ffvf_pkg::PIX_W-1:0] r_even_rd;
    logic [ffvf_pkg::PIX_W-1:0] r_odd_rd;

    // Stage one: the accepted pixel and what it issues.
    logic                       r_s1_vld;
    logic                       r_s1_issue;
    logic                       r_s1_odd;
    logic                       r_s1_end;
    logic [ffvf_pkg::PIX_W-1:0] r_s1_pix;

    // Output register.
    logic                       r_out_vld;
    logic [ffvf_pkg::PIX_W-1:0] r_out_pix;
    logic                       r_out_end;

    // Combinational signals.
    logic [ffvf_pkg::WID_W-1:0] w_eff_width;
    logic [ffvf_pkg::RWS_W-1:0] w_eff_rows;
    logic [ffvf_pkg::RWS_W:0]   w_frame_rows;
    logic [ffvf_pkg::COL_W-1:0] w_col;
    logic [ffvf_pkg::ROW_W-1:0] w_row;
    logic                       w_last_col;
    logic                       w_row_odd;
    logic                       w_issue_even;
    logic                       w_issue_odd;
    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_s1_adv;
    logic                       w_out_load;
    logic [ffvf_pkg::SUM_W-1:0] w_sum;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= ffvf_pkg::LINE_WIDTH_RST;
            r_field_rows <= ffvf_pkg::FIELD_ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ffvf_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[ffvf_pkg::LINE_WIDTH_W-1:0];
                end
                ffvf_pkg::CFG_FIELD_ROWS: begin
                    r_field_rows <= i_cfg_data[ffvf_pkg::FIELD_ROWS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective row length and field height: zero acts as one, large values clamp.
    always_comb begin
        if (r_line_width == '0) begin
            w_eff_width = ffvf_pkg::WID_W'(1);
        end else if (32'(r_line_width) > ffvf_pkg::MAX_WIDTH) begin
            w_eff_width = ffvf_pkg::WID_W'(ffvf_pkg::MAX_WIDTH);
        end else begin
            w_eff_width = ffvf_pkg::WID_W'(r_line_width);
        end

        if (r_field_rows == '0) begin
            w_eff_rows = ffvf_pkg::RWS_W'(1);
        end else if (32'(r_field_rows) > ffvf_pkg::MAX_FIELD_ROWS) begin
            w_eff_rows = ffvf_pkg::RWS_W'(ffvf_pkg::MAX_FIELD_ROWS);
        end else begin
            w_eff_rows = ffvf_pkg::RWS_W'(r_field_rows);
        end
    end

    assign w_frame_rows = {w_eff_rows, 1'b0};

    // Position of the incoming pixel; a frame start puts it at row 0, column 0.
    assign w_col       = i_src.frame_start ? '0 : r_col;
    assign w_row       = i_src.frame_start ? '0 : r_row;
    assign w_row_odd   = w_row[0];
    assign w_last_col  = (32'(w_col) + 32'd1) >= 32'(w_eff_width);

    // Even rows from row 2 complete the row above; the last odd row completes
    // the last field row on its own.
    assign w_issue_even = !w_row_odd && (32'(w_row) >= 32'd2)
                          && (32'(w_row) < 32'(w_frame_rows));
    assign w_issue_odd  = w_row_odd && ((32'(w_row) + 32'd1) == 32'(w_frame_rows));

    // Next counter values.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_last_col) begin
            n_col = '0;
            if ((32'(w_row) + 32'd1) >= 32'(w_frame_rows)) begin
                n_row = '0;
            end else begin
                n_row = w_row + ffvf_pkg::ROW_W'(1);
            end
        end else begin
            n_col = w_col + ffvf_pkg::COL_W'(1);
            n_row = w_row;
        end
    end

    // Handshake: stage one moves on when empty, when it issues nothing, or
    // when the output register can take its result.
    assign w_accept   = i_src.valid && i_src.ready;
    assign w_out_free = !r_out_vld || o_dst.ready;
    assign w_s1_adv   = !r_s1_vld || !r_s1_issue || w_out_free;
    assign w_out_load = r_s1_vld && r_s1_issue && w_out_free;
    assign i_src.ready = w_s1_adv;

    // Counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Even line store: read-first, written on even rows.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_even_rd <= r_even_line[w_col];
            if (!w_row_odd) begin
                r_even_line[w_col] <= i_src.pixel_in;
            end
        end
    end

    // Odd line store: read-first, written on odd rows.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_odd_rd <= r_odd_line[w_col];
            if (w_row_odd) begin
                r_odd_line[w_col] <= i_src.pixel_in;
            end
        end
    end

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_vld <= w_accept;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_issue <= w_issue_even || w_issue_odd;
            r_s1_odd   <= w_row_odd;
            r_s1_end   <= w_issue_odd && w_last_col;
            r_s1_pix   <= i_src.pixel_in;
        end
    end

    // Filter sum: 1-2-1 over three rows, or even + 3*odd on the last field row.
    always_comb begin
        if (r_s1_odd) begin
            w_sum = ffvf_pkg::SUM_W'(r_even_rd)
                  + {1'b0, r_s1_pix, 1'b0}
                  + ffvf_pkg::SUM_W'(r_s1_pix)
                  + ffvf_pkg::SUM_W'(ffvf_pkg::ROUND_BIAS);
        end else begin
            w_sum = ffvf_pkg::SUM_W'(r_even_rd)
                  + {1'b0, r_odd_rd, 1'b0}
                  + ffvf_pkg::SUM_W'(r_s1_pix)
                  + ffvf_pkg::SUM_W'(ffvf_pkg::ROUND_BIAS);
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_out_load;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pix <= w_sum[ffvf_pkg::SUM_W-1:2];
            r_out_end <= r_s1_end;
        end
    end

    assign o_dst.valid     = r_out_vld;
    assign o_dst.pixel_out = r_out_pix;
    assign o_dst.field_end = r_out_end;

    // The pixel that ends a field always wraps the counters to the frame origin.
    a_field_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_issue_odd && w_last_col) |=> (r_col == '0 && r_row == '0))
        else $error("field end did not wrap the position counters");

    // A waiting result is never dropped.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_dst.ready) |=> r_out_vld)
        else $error("pending field pixel was lost");

    // A stage one result that cannot move blocks new source pixels.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_issue && r_out_vld && !o_dst.ready) |-> !i_src.ready)
        else $error("source accepted while the pipeline was stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_s1_vld))
        else $error("pipeline not empty after reset");

endmodule
